// ===== sv/deadline_sorted_timer_queue_assert.svh =====
// Assertion macros for the timer queue.
`ifndef DEADLINE_SORTED_TIMER_QUEUE_ASSERT_SVH
`define DEADLINE_SORTED_TIMER_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define DSTQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DSTQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DSTQ_ASSERT(lbl, clk, rst, prop, msg)
`define DSTQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/dstq_pkg.sv =====
`timescale 1ns / 1ps
package dstq_pkg;
  localparam int DSTQ_SLOTS     = 16;
  localparam int DSTQ_MAX_FIRED = 32;
  localparam logic [31:0] FIRST_ID = 32'h2000_0000;

  localparam logic [2:0] OP_CREATE     = 3'd0;
  localparam logic [2:0] OP_CLEAR      = 3'd1;
  localparam logic [2:0] OP_CLEAR_ANIM = 3'd2;
  localparam logic [2:0] OP_REMOVE     = 3'd3;
  localparam logic [2:0] OP_TICK       = 3'd4;

  localparam logic [1:0] KIND_TIMEOUT  = 2'd0;
  localparam logic [1:0] KIND_INTERVAL = 2'd1;
  localparam logic [1:0] KIND_ANIM     = 2'd2;
  localparam logic [1:0] KIND_BAD      = 2'd3;

  localparam logic [1:0] RK_ACK  = 2'd0;
  localparam logic [1:0] RK_FIRE = 2'd1;
  localparam logic [1:0] RK_DONE = 2'd2;

  localparam logic [1:0] WA_LEAVE = 2'd0;
  localparam logic [1:0] WA_SET   = 2'd1;
  localparam logic [1:0] WA_STOP  = 2'd2;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [31:0]        now_ms;
    logic signed [31:0] delay_ms;
    logic [1:0]         kind_in;
    logic [31:0]        owner_in;
    logic [31:0]        id_in;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic        status;
    logic [31:0] id_out;
    logic [1:0]  kind_out;
    logic [31:0] owner_out;
    logic [1:0]  wake_action;
    logic [31:0] wake_delay;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [31:0] deadline;
    logic [31:0] id;
    logic [31:0] owner;
    logic [30:0] interval;
    logic [1:0]  kind;
  } entry_t;
endpackage

// ===== sv/deadline_sorted_timer_queue.sv =====
`timescale 1ns / 1ps
// Channel | Ports             | Handshake
// command | cmd (cmd_t)       | taken when start && !busy
// result  | res (res_t)       | one cycle each, marked by strobe
//
// Commands run one at a time; busy stays high until the last result beat.
// Cost is set by the entry RAM (one read and one write port, registered read):
// a scan or shift step is a read state and a check or write state, so create
// and clear grow with the entry count, remove-owner with its square when
// every entry is dropped, and a tick with the count for each fired timer.
// Reset empties the queue at once; RAM contents need no clearing.
// The receiver cannot stall; results are never held.
module deadline_sorted_timer_queue
  import dstq_pkg::*;
#(
  parameter int TIMER_SLOTS = DSTQ_SLOTS,
  parameter int MAX_FIRED   = DSTQ_MAX_FIRED
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic strobe,
  output res_t res
);
`include "deadline_sorted_timer_queue_assert.svh"

  localparam int IW = $clog2(TIMER_SLOTS);
  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam int NW = $clog2(MAX_FIRED + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INS_GO   = 4'd1;
  localparam logic [3:0] S_INS_RD   = 4'd2;
  localparam logic [3:0] S_INS_CHK  = 4'd3;
  localparam logic [3:0] S_INS_HEAD = 4'd4;
  localparam logic [3:0] S_RM_RD    = 4'd5;
  localparam logic [3:0] S_RM_WR    = 4'd6;
  localparam logic [3:0] S_SC_RD    = 4'd7;
  localparam logic [3:0] S_SC_CHK   = 4'd8;
  localparam logic [3:0] S_HD_RD    = 4'd9;
  localparam logic [3:0] S_HD_CHK   = 4'd10;

  logic [3:0]    state;
  logic [CW-1:0] cnt;
  logic [31:0]   next_id;
  logic [CW-1:0] i;
  logic [IW-1:0] j;
  logic [IW-1:0] lpos;
  logic [NW-1:0] n;
  logic          lf;
  logic          ivl_nz;
  logic [2:0]    op;
  logic [31:0]   now;
  logic [31:0]   owner;
  logic [31:0]   id;
  entry_t        ins;

  logic          we;
  logic [IW-1:0] waddr;
  logic [IW-1:0] raddr;
  entry_t        wdata;
  entry_t        rd;

  logic [31:0]   dly;
  logic [1:0]    kfix;
  logic          rd_later;
  logic [31:0]   hd_diff;

  function automatic res_t mk(logic [1:0] rk, logic st, logic [31:0] rid, logic [1:0] rkd,
                              logic [31:0] rown, logic [1:0] wa, logic [31:0] wd, logic lst);
    res_t r;
    r.result_kind = rk;
    r.status      = st;
    r.id_out      = rid;
    r.kind_out    = rkd;
    r.owner_out   = rown;
    r.wake_action = wa;
    r.wake_delay  = wd;
    r.last        = lst;
    return r;
  endfunction

  dstq_ram #(.WIDTH($bits(entry_t)), .DEPTH(TIMER_SLOTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd)
  );

  assign busy     = (state != S_IDLE);
  assign dly      = (cmd.delay_ms < 32'sd1) ? 32'd1 : cmd.delay_ms;
  assign kfix     = (cmd.kind_in == KIND_BAD) ? KIND_TIMEOUT : cmd.kind_in;
  assign rd_later = (rd.deadline > ins.deadline);
  assign hd_diff  = rd.deadline - now;

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = ins;
    raddr = '0;
    unique case (state)
      S_SC_RD:  raddr = i[IW-1:0];
      S_INS_RD: raddr = j;
      S_RM_RD:  raddr = j + IW'(1);
      S_INS_CHK: begin
        we    = 1'b1;
        waddr = j + IW'(1);
        wdata = rd_later ? rd : ins;
      end
      S_INS_HEAD: we = 1'b1;
      S_RM_WR: begin
        we    = 1'b1;
        waddr = j;
        wdata = rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      next_id <= FIRST_ID;
      strobe  <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op    <= cmd.opcode;
            now   <= cmd.now_ms;
            owner <= cmd.owner_in;
            id    <= cmd.id_in;
            i     <= '0;
            priority case (cmd.opcode)
              OP_CREATE: begin
                if (cnt >= CW'(TIMER_SLOTS)) begin
                  res    <= mk(RK_ACK, 1'b1, '0, '0, '0, WA_LEAVE, '0, 1'b1);
                  strobe <= 1'b1;
                end else begin
                  ins.deadline <= cmd.now_ms + dly;
                  ins.id       <= next_id;
                  ins.owner    <= cmd.owner_in;
                  ins.interval <= (kfix == KIND_INTERVAL) ? dly[30:0] : '0;
                  ins.kind     <= kfix;
                  next_id      <= next_id + 32'd1;
                  state        <= S_INS_GO;
                end
              end
              OP_CLEAR, OP_CLEAR_ANIM, OP_REMOVE: state <= S_SC_RD;
              OP_TICK: begin
                if (cnt == '0) begin
                  res    <= mk(RK_DONE, 1'b0, '0, '0, '0, WA_STOP, '0, 1'b1);
                  strobe <= 1'b1;
                end else begin
                  lpos  <= IW'(cnt - CW'(1));
                  n     <= '0;
                  lf    <= 1'b0;
                  state <= S_HD_RD;
                end
              end
              default: begin
                res    <= mk(RK_DONE, 1'b0, '0, '0, '0, WA_LEAVE, '0, 1'b1);
                strobe <= 1'b1;
              end
            endcase
          end
        end
        S_INS_GO: begin
          if (cnt == '0) begin
            state <= S_INS_HEAD;
          end else begin
            j     <= IW'(cnt - CW'(1));
            state <= S_INS_RD;
          end
        end
        S_INS_RD: state <= S_INS_CHK;
        S_INS_CHK, S_INS_HEAD: begin
          // shift the later entry up one slot and keep walking down
          if (state == S_INS_CHK && rd_later && j != '0) begin
            j     <= j - IW'(1);
            state <= S_INS_RD;
          end else if (state == S_INS_CHK && rd_later) begin
            state <= S_INS_HEAD;
          end else begin
            cnt <= cnt + CW'(1);
            if (op == OP_CREATE) begin
              if (state == S_INS_HEAD) begin
                res <= mk(RK_ACK, 1'b0, ins.id, '0, '0, WA_SET, ins.deadline - now, 1'b1);
              end else begin
                res <= mk(RK_ACK, 1'b0, ins.id, '0, '0, WA_LEAVE, '0, 1'b1);
              end
              strobe <= 1'b1;
              state  <= S_IDLE;
            end else begin
              if (!lf && (state == S_INS_HEAD || (j + IW'(1)) <= lpos)) begin
                lpos <= lpos + IW'(1);
              end
              state <= S_HD_RD;
            end
          end
        end
        S_RM_RD: begin
          if ((CW'(j) + CW'(1)) < cnt) begin
            state <= S_RM_WR;
          end else begin
            cnt <= cnt - CW'(1);
            priority case (op)
              OP_REMOVE: state <= S_SC_RD;
              OP_TICK: begin
                if (!lf) begin
                  lpos <= lpos - IW'(1);
                end
                state <= ivl_nz ? S_INS_GO : S_HD_RD;
              end
              default: begin
                res    <= mk(RK_DONE, 1'b0, '0, '0, '0, WA_LEAVE, '0, 1'b1);
                strobe <= 1'b1;
                state  <= S_IDLE;
              end
            endcase
          end
        end
        S_RM_WR: begin
          j     <= j + IW'(1);
          state <= S_RM_RD;
        end
        S_SC_RD: begin
          if (i < cnt) begin
            state <= S_SC_CHK;
          end else if (op == OP_REMOVE) begin
            state <= S_HD_RD;
          end else begin
            res    <= mk(RK_DONE, 1'b0, '0, '0, '0, WA_LEAVE, '0, 1'b1);
            strobe <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_SC_CHK: begin
          j <= i[IW-1:0];
          if (op == OP_REMOVE) begin
            if (rd.owner == owner) begin
              state <= S_RM_RD;
            end else begin
              i     <= i + CW'(1);
              state <= S_SC_RD;
            end
          end else if (rd.id == id && rd.owner == owner) begin
            if ((op == OP_CLEAR_ANIM) == (rd.kind == KIND_ANIM)) begin
              state <= S_RM_RD;
            end else begin
              res    <= mk(RK_DONE, 1'b0, '0, '0, '0, WA_LEAVE, '0, 1'b1);
              strobe <= 1'b1;
              state  <= S_IDLE;
            end
          end else begin
            i     <= i + CW'(1);
            state <= S_SC_RD;
          end
        end
        S_HD_RD: begin
          if (cnt != '0) begin
            state <= S_HD_CHK;
          end else begin
            res    <= mk(RK_DONE, 1'b0, '0, '0, '0,
                         (op == OP_TICK) ? WA_STOP : WA_LEAVE, '0, 1'b1);
            strobe <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_HD_CHK: begin
          if (op == OP_REMOVE) begin
            res    <= mk(RK_DONE, 1'b0, '0, '0, '0, WA_SET,
                         hd_diff[31] ? 32'd0 : hd_diff, 1'b1);
            strobe <= 1'b1;
            state  <= S_IDLE;
          end else if (lf || n >= NW'(MAX_FIRED) || rd.deadline > now) begin
            res    <= mk(RK_DONE, 1'b0, '0, '0, '0, WA_SET,
                         (rd.deadline > now) ? hd_diff : 32'd0, 1'b1);
            strobe <= 1'b1;
            state  <= S_IDLE;
          end else begin
            // fire the head, then drop it and requeue if periodic
            res    <= mk(RK_FIRE, 1'b0, rd.id, rd.kind, rd.owner, WA_LEAVE, '0, 1'b0);
            strobe <= 1'b1;
            ins    <= '{deadline: rd.deadline + {1'b0, rd.interval}, id: rd.id,
                        owner: rd.owner, interval: rd.interval, kind: rd.kind};
            ivl_nz <= (rd.interval != '0);
            lf     <= (lpos == '0);
            n      <= n + NW'(1);
            j      <= '0;
            state  <= S_RM_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `DSTQ_ASSERT(a_write_busy, clk, rst, we |-> busy, "RAM write while idle")
  `DSTQ_ASSERT(a_cnt_range, clk, rst, cnt <= CW'(TIMER_SLOTS), "entry count overflow")
  `DSTQ_ASSERT(a_last_idle, clk, rst, strobe && res.last |-> !busy, "last beat while busy")
  `DSTQ_ASSERT(a_fire_busy, clk, rst, strobe && !res.last |-> busy, "fire beat ends command")
  `DSTQ_ASSERT(a_start_acts, clk, rst, start && !busy |=> busy || strobe, "command dropped")
endmodule

// ===== sv/dstq_ram.sv =====
`timescale 1ns / 1ps
module dstq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== bench/deadline_sorted_timer_queue_checker.sv =====
`timescale 1ns / 1ps
module deadline_sorted_timer_queue_checker
  import dstq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  cmd_t        cmd,
  input  logic        strobe,
  input  res_t        res,
  output int          fail_count,
  output int          pending,
  output int          fire_seen,
  output int          cmd_seen
);
  entry_t timers[$];
  logic [31:0] id_counter;
  res_t expected_beats[$];

  function automatic int slot_after(input logic [31:0] d);
    for (int i = 0; i < timers.size(); i++)
      if (timers[i].deadline > d) return i;
    return timers.size();
  endfunction

  function automatic res_t beat(input logic [1:0] rk, input logic st,
                                input logic [31:0] id, input logic [1:0] k,
                                input logic [31:0] own, input logic [1:0] wa,
                                input logic [31:0] wd, input logic lst);
    res_t r;
    r.result_kind = rk; r.status = st; r.id_out = id; r.kind_out = k;
    r.owner_out = own; r.wake_action = wa; r.wake_delay = wd; r.last = lst;
    return r;
  endfunction

  task automatic predict_command(input cmd_t c);
    logic [1:0] k;
    logic [31:0] dly, d, diff, hd;
    entry_t e;
    int p, nfired, last_pos;
    bit last_fired;
    k = (c.kind_in == KIND_BAD) ? KIND_TIMEOUT : c.kind_in;
    case (c.opcode)
      OP_CREATE: begin
        if (timers.size() >= DSTQ_SLOTS) begin
          expected_beats.push_back(beat(RK_ACK, 1'b1, '0, '0, '0, WA_LEAVE, '0, 1'b1));
        end else begin
          dly = (c.delay_ms[31] || c.delay_ms == 0) ? 32'd1 : c.delay_ms;
          d = c.now_ms + dly;
          p = slot_after(d);
          e.deadline = d; e.id = id_counter; e.owner = c.owner_in;
          e.interval = (k == KIND_INTERVAL) ? dly[30:0] : '0; e.kind = k;
          timers.insert(p, e);
          expected_beats.push_back(beat(RK_ACK, 1'b0, id_counter, '0, '0,
                                        p == 0 ? WA_SET : WA_LEAVE,
                                        p == 0 ? dly : '0, 1'b1));
          id_counter++;
        end
      end
      OP_CLEAR, OP_CLEAR_ANIM: begin
        for (int i = 0; i < timers.size(); i++)
          if (timers[i].id == c.id_in && timers[i].owner == c.owner_in) begin
            if ((c.opcode == OP_CLEAR_ANIM) == (timers[i].kind == KIND_ANIM))
              timers.delete(i);
            break;
          end
        expected_beats.push_back(beat(RK_DONE, 1'b0, '0, '0, '0, WA_LEAVE, '0, 1'b1));
      end
      OP_REMOVE: begin
        for (int i = timers.size() - 1; i >= 0; i--)
          if (timers[i].owner == c.owner_in) timers.delete(i);
        if (timers.size() > 0) begin
          diff = timers[0].deadline - c.now_ms;
          if (diff[31]) diff = '0;
          expected_beats.push_back(beat(RK_DONE, 1'b0, '0, '0, '0, WA_SET, diff, 1'b1));
        end else begin
          expected_beats.push_back(beat(RK_DONE, 1'b0, '0, '0, '0, WA_LEAVE, '0, 1'b1));
        end
      end
      OP_TICK: begin
        if (timers.size() == 0) begin
          expected_beats.push_back(beat(RK_DONE, 1'b0, '0, '0, '0, WA_STOP, '0, 1'b1));
        end else begin
          nfired = 0; last_fired = 0; last_pos = timers.size() - 1;
          while (1) begin
            if (timers.size() == 0) begin
              expected_beats.push_back(beat(RK_DONE, 1'b0, '0, '0, '0, WA_STOP, '0, 1'b1));
              break;
            end
            hd = timers[0].deadline;
            if (last_fired || nfired >= DSTQ_MAX_FIRED || hd > c.now_ms) begin
              expected_beats.push_back(beat(RK_DONE, 1'b0, '0, '0, '0, WA_SET,
                                            hd > c.now_ms ? hd - c.now_ms : '0, 1'b1));
              break;
            end
            e = timers.pop_front();
            last_fired = (last_pos == 0);
            if (!last_fired) last_pos--;
            if (e.interval != 0) begin
              e.deadline = hd + e.interval;
              p = slot_after(e.deadline);
              timers.insert(p, e);
              if (!last_fired && p <= last_pos) last_pos++;
            end
            expected_beats.push_back(beat(RK_FIRE, 1'b0, e.id, e.kind, e.owner,
                                          WA_LEAVE, '0, 1'b0));
            nfired++;
          end
        end
      end
      default: begin
        expected_beats.push_back(beat(RK_DONE, 1'b0, '0, '0, '0, WA_LEAVE, '0, 1'b1));
      end
    endcase
  endtask

  task automatic compare_beat(input res_t got);
    res_t want;
    if (expected_beats.size() == 0) begin
      $error("result beat with nothing expected: %p", got);
      fail_count++;
      return;
    end
    want = expected_beats.pop_front();
    if (got.result_kind !== want.result_kind) begin
      $error("result_kind exp %0d got %0d", want.result_kind, got.result_kind); fail_count++;
    end
    if (got.status !== want.status) begin
      $error("status exp %0d got %0d", want.status, got.status); fail_count++;
    end
    if (got.id_out !== want.id_out) begin
      $error("id_out exp %h got %h", want.id_out, got.id_out); fail_count++;
    end
    if (got.kind_out !== want.kind_out) begin
      $error("kind_out exp %0d got %0d", want.kind_out, got.kind_out); fail_count++;
    end
    if (got.owner_out !== want.owner_out) begin
      $error("owner_out exp %h got %h", want.owner_out, got.owner_out); fail_count++;
    end
    if (got.wake_action !== want.wake_action) begin
      $error("wake_action exp %0d got %0d", want.wake_action, got.wake_action); fail_count++;
    end
    if (got.wake_delay !== want.wake_delay) begin
      $error("wake_delay exp %0d got %0d", want.wake_delay, got.wake_delay); fail_count++;
    end
    if (got.last !== want.last) begin
      $error("last exp %0d got %0d", want.last, got.last); fail_count++;
    end
  endtask

  initial begin
    fail_count = 0; fire_seen = 0; cmd_seen = 0;
    id_counter = FIRST_ID;
  end

  assign pending = expected_beats.size();

  always @(posedge clk) begin
    if (rst) begin
      timers.delete();
      expected_beats.delete();
      id_counter = FIRST_ID;
    end else begin
      // compare before predicting: a new beat can't belong to a command taken now
      if (strobe) begin
        if (res.result_kind == RK_FIRE) fire_seen++;
        compare_beat(res);
      end
      if (start && !busy) begin
        cmd_seen++;
        predict_command(cmd);
      end
    end
  end
endmodule

// ===== bench/deadline_sorted_timer_queue_tb.sv =====
`timescale 1ns / 1ps
module deadline_sorted_timer_queue_tb;
  import dstq_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, strobe;
  cmd_t cmd = '0;
  res_t res;
  int fail_count, pending, fire_seen, cmd_seen;
  int idle_cycles = 0;
  logic [31:0] clock_ms = 32'd1000;
  logic [31:0] owners[4] = '{32'h0000_0001, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 32'h0};
  logic [31:0] ids_issued[$];

  always #6 clk = ~clk;

  deadline_sorted_timer_queue DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .strobe(strobe), .res(res)
  );

  deadline_sorted_timer_queue_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .strobe(strobe), .res(res), .fail_count(fail_count), .pending(pending),
    .fire_seen(fire_seen), .cmd_seen(cmd_seen)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("simulation failed");
      $finish;
    end
  end

  // drive one command and hold it until taken
  task automatic issue(input logic [2:0] op, input logic [31:0] now,
                       input logic [31:0] dly, input logic [1:0] k,
                       input logic [31:0] own, input logic [31:0] id);
    cmd_t c;
    c.opcode = op; c.now_ms = now; c.delay_ms = dly; c.kind_in = k;
    c.owner_in = own; c.id_in = id;
    cmd <= c;
    start <= 1'b1;
    do @(posedge clk); while (!(start && !busy));
    if (op == OP_CREATE) ids_issued.push_back(ids_issued.size() + FIRST_ID);
  endtask

  task automatic rest(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_owner();
    return ($urandom_range(0, 9) == 0) ? $urandom() : owners[$urandom_range(0, 3)];
  endfunction

  function automatic logic [31:0] pick_id();
    if (ids_issued.size() == 0 || $urandom_range(0, 5) == 0) return $urandom();
    return ids_issued[$urandom_range(0, ids_issued.size() - 1)];
  endfunction

  initial begin
    int burst;
    logic [31:0] dly;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty tick, delay extremes, bad kind, full table, clears
    issue(OP_TICK, 32'd0, 0, KIND_TIMEOUT, 0, 0);
    issue(OP_CREATE, 32'hFFFF_FFF0, 32'h8000_0000, KIND_INTERVAL, owners[1], 0);
    issue(OP_CREATE, 32'hFFFF_FFF0, 32'd0, KIND_BAD, owners[0], 0);
    issue(OP_CREATE, 32'd0, 32'h7FFF_FFFF, KIND_INTERVAL, owners[2], 0);
    issue(OP_CREATE, 32'd5, 32'd5, KIND_ANIM, owners[0], 0);
    issue(OP_CLEAR, 32'd5, 0, KIND_TIMEOUT, owners[0], FIRST_ID + 3);
    issue(OP_CLEAR_ANIM, 32'd5, 0, KIND_TIMEOUT, owners[1], FIRST_ID + 3);
    issue(OP_CLEAR_ANIM, 32'd5, 0, KIND_TIMEOUT, owners[0], FIRST_ID + 3);
    issue(OP_CLEAR, 32'd5, 0, KIND_TIMEOUT, owners[0], FIRST_ID + 1);
    for (int i = 0; i < 15; i++)
      issue(OP_CREATE, 32'd10, 32'(i % 3 + 1), KIND_INTERVAL, owners[i % 4], 0);
    issue(OP_TICK, 32'hFFFF_FFFF, 0, KIND_TIMEOUT, 0, 0);
    issue(OP_REMOVE, 32'd20, 0, KIND_TIMEOUT, owners[1], 0);
    issue(3'd7, 32'd20, 0, KIND_TIMEOUT, 0, 0);
    issue(3'd5, 32'd20, 0, KIND_TIMEOUT, 0, 0);
    for (int i = 0; i < 4; i++) issue(OP_REMOVE, 32'd30, 0, KIND_TIMEOUT, owners[i], 0);
    issue(OP_TICK, 32'd30, 0, KIND_TIMEOUT, 0, 0);
    drain();

    // random: mostly creates and ticks on an advancing clock, bursts and gaps
    for (int n = 0; n < 70; ) begin
      burst = $urandom_range(1, 8);
      for (int b = 0; b < burst; b++, n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            case ($urandom_range(0, 5))
              0: dly = $urandom();
              1: dly = 32'h8000_0000 | $urandom();
              default: dly = $urandom_range(0, 40);
            endcase
            issue(OP_CREATE, clock_ms, dly, 2'($urandom_range(0, 3)), pick_owner(), 0);
          end
          4, 5, 6: begin
            clock_ms = clock_ms + $urandom_range(0, 30);
            issue(OP_TICK, ($urandom_range(0, 15) == 0) ? $urandom() : clock_ms,
                  $urandom(), 2'($urandom_range(0, 3)), $urandom(), $urandom());
          end
          7: issue(OP_CLEAR, clock_ms, $urandom(), 2'($urandom_range(0, 3)),
                   pick_owner(), pick_id());
          8: issue(OP_CLEAR_ANIM, clock_ms, $urandom(), 2'($urandom_range(0, 3)),
                   pick_owner(), pick_id());
          default: issue(($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7)) : OP_REMOVE,
                         ($urandom_range(0, 3) == 0) ? $urandom() : clock_ms,
                         $urandom(), 2'($urandom_range(0, 3)), pick_owner(), $urandom());
        endcase
        if ($urandom_range(0, 3) == 0) rest($urandom_range(1, 20));
      end
      if ($urandom_range(0, 9) == 0) drain();
      else rest($urandom_range(0, 40));
    end

    drain();
    $display("covered %0d commands, %0d timer fires, delay extremes, full table,",
             cmd_seen, fire_seen);
    $display("kind-mismatched clears, owner removal, wrapping clock and bad opcodes");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
